// ----- rtl/core/tld_pkg.sv -----
// Shared types and constants for the tty line discipline block.
// Used by tld_ring, tld_line, tty_line_discipline and the testbench.
package tld_pkg;

	localparam int RING_DEPTH_DEF = 256;

	localparam int ACT_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int CNT16_W = 16;
	localparam int FILL_W  = 9;

	localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ARM  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POP  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

	localparam logic [CNT16_W-1:0] CNT16_MAX = 16'hFFFF;

	typedef struct packed {
		logic                valid;
		logic [ACT_W-1:0]    action;
		logic                dropped;
		logic                popped;
		logic [CNT16_W-1:0]  request_count;
		logic [FILL_W-1:0]   fill_level;
	} s1_t;

	typedef struct packed {
		logic                push_dropped;
		logic                popped_valid;
		logic                echo_valid;
		logic [BYTE_W-1:0]   echo_char;
		logic                echo_newline;
		logic                store_valid;
		logic [CNT16_W-1:0]  store_offset;
		logic [BYTE_W-1:0]   store_byte;
		logic                done_res;
		logic [CNT16_W-1:0]  done_count;
		logic [FILL_W-1:0]   fill_level;
	} res_t;

endpackage

// ----- rtl/core/tld_ring.sv -----
// Key ring: byte memory with registered read port, pointers and fill count.
// Feeds stage 1 (tld_pkg::s1_t plus read byte) to tld_line.
module tld_ring #(
	parameter int RING_DEPTH = tld_pkg::RING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          advance,
	input  logic [tld_pkg::ACT_W-1:0]     action,
	input  logic [tld_pkg::BYTE_W-1:0]    key_code,
	input  logic [tld_pkg::CNT16_W-1:0]   request_count,
	output tld_pkg::s1_t                  s1,
	output logic [tld_pkg::BYTE_W-1:0]    rd_byte
);
	import tld_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

	logic [BYTE_W-1:0] mem [RING_DEPTH];
	logic [BYTE_W-1:0] rd_byte_s1;

	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] held_q, held_nxt;
	logic             full, empty, do_wr, do_rd;
	s1_t              s1_q;

	assign full     = (held_q == CNT_FULL);
	assign empty    = (held_q == '0);
	assign do_wr    = accept && (action == ACT_PUSH) && !full;
	assign do_rd    = accept && (action == ACT_POP) && !empty;

	always_comb begin
		held_nxt = held_q;
		if (do_wr) begin
			held_nxt = held_q + CNT_W'(1);
		end else if (do_rd) begin
			held_nxt = held_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wp_q] <= key_code;
		end
		if (do_rd) begin
			rd_byte_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			held_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
			end
			held_q <= held_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (accept) begin
			s1_q.valid         <= 1'b1;
			s1_q.action        <= action;
			s1_q.dropped       <= (action == ACT_PUSH) && full;
			s1_q.popped        <= (action == ACT_POP) && !empty;
			s1_q.request_count <= request_count;
			s1_q.fill_level    <= FILL_W'(held_nxt);
		end else if (advance) begin
			s1_q.valid <= 1'b0;
		end
	end

	assign s1      = s1_q;
	assign rd_byte = rd_byte_s1;

endmodule

// ----- rtl/core/tld_line.sv -----
// Line discipline stage: request counters, echo/store/done decode, output register.
// Consumes tld_pkg::s1_t and the ring read byte from tld_ring.
module tld_line (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tld_pkg::s1_t                  s1,
	input  logic [tld_pkg::BYTE_W-1:0]    rd_byte,
	input  logic                          out_ready,
	output logic                          advance,
	output logic                          out_valid,
	output tld_pkg::res_t                 res
);
	import tld_pkg::*;

	logic [CNT16_W-1:0] rem_q, xfer_q, rem_nxt, xfer_nxt, rem_mid, xfer_mid;
	logic               out_valid_q, printable, active;
	res_t               res_q, res_nxt;

	assign advance   = s1.valid && (!out_valid_q || out_ready);
	assign printable = (rd_byte >= CH_SPACE) && (rd_byte <= CH_TILDE);
	assign active    = s1.popped && (rem_q != '0);

	always_comb begin
		res_nxt              = '0;
		res_nxt.push_dropped = s1.dropped;
		res_nxt.popped_valid = s1.popped;
		res_nxt.fill_level   = s1.fill_level;
		rem_mid  = rem_q;
		xfer_mid = xfer_q;
		rem_nxt  = rem_q;
		xfer_nxt = xfer_q;
		if (s1.action == ACT_ARM) begin
			rem_nxt  = s1.request_count;
			xfer_nxt = '0;
		end else if (active) begin
			if (printable) begin
				res_nxt.echo_valid   = 1'b1;
				res_nxt.echo_char    = rd_byte;
				res_nxt.store_valid  = 1'b1;
				res_nxt.store_offset = xfer_q;
				res_nxt.store_byte   = rd_byte;
				xfer_mid = (xfer_q < CNT16_MAX) ? xfer_q + 16'd1 : xfer_q;
				rem_mid  = rem_q - 16'd1;
			end else if ((rd_byte == CH_BS) && (xfer_q != '0)) begin
				res_nxt.echo_valid = 1'b1;
				res_nxt.echo_char  = rd_byte;
				xfer_mid = xfer_q - 16'd1;
				rem_mid  = (rem_q < CNT16_MAX) ? rem_q + 16'd1 : rem_q;
			end
			xfer_nxt = xfer_mid;
			rem_nxt  = rem_mid;
			if ((rd_byte == CH_NL) || (rem_mid == '0)) begin
				res_nxt.echo_newline = 1'b1;
				res_nxt.done_res     = 1'b1;
				res_nxt.done_count   = xfer_mid;
				rem_nxt              = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			xfer_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				rem_q       <= rem_nxt;
				xfer_q      <= xfer_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/core/tty_line_discipline.sv -----
// Keyboard ring buffer with canonical line discipline, top level.
// An input transaction is registered in the ring read stage, then in the line stage output register.
// Throughput: one transaction per cycle while m_axis_tready does not stall the output; the ring
// memory's single read and write port and the one-item-per-cycle line counter update set this rate.
// Reset: pointers, fill count, request counters and valid flags clear at once;
// ring contents are not cleared and are never read before written.
module tty_line_discipline #(
	parameter int RING_DEPTH = tld_pkg::RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // key_code[7:0], request_count[23:8]
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // push_dropped[0], popped_valid[1], echo_valid[2],
	                                    // echo_char[10:3], echo_newline[11], store_valid[12],
	                                    // store_offset[28:13], store_byte[36:29],
	                                    // done_res[37], done_count[53:38], fill_level[62:54]
);
	import tld_pkg::*;

	logic              accept, advance;
	s1_t               s1;
	logic [BYTE_W-1:0] rd_byte;
	res_t              res;

	assign s_axis_tready = !s1.valid || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	tld_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.advance       (advance),
		.action        (s_axis_tuser),
		.key_code      (s_axis_tdata[7:0]),
		.request_count (s_axis_tdata[23:8]),
		.s1            (s1),
		.rd_byte       (rd_byte)
	);

	tld_line u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.rd_byte   (rd_byte),
		.out_ready (m_axis_tready),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tdata = {1'b0, res.fill_level, res.done_count, res.done_res,
		res.store_byte, res.store_offset, res.store_valid, res.echo_newline,
		res.echo_char, res.echo_valid, res.popped_valid, res.push_dropped};

endmodule

// ----- rtl/core/tld_checker.sv -----
// Port-level checker for tty_line_discipline, attached by bind.
// Depends only on the top-level ports.
module tld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_done_newline: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[11] == m_axis_tdata[37]))
		else $error("newline echo and completion disagree");

	a_store_echo: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |->
			m_axis_tdata[2] && m_axis_tdata[1] && (m_axis_tdata[10:3] == m_axis_tdata[36:29]))
		else $error("store without matching echo");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |->
			!m_axis_tdata[1] && !m_axis_tdata[2] && !m_axis_tdata[37])
		else $error("dropped push reported pop activity");

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for tty_line_discipline: directed table, then random line traffic.
// Keeps its own model of the key ring and the read request to predict every result not fixed by the table.
// Depends on tld_pkg and the tty_line_discipline RTL.
module testbench;
	import tld_pkg::*;

	localparam int RING_SLOTS = RING_DEPTH_DEF;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam int N_DIRECTED = 25;
	localparam int N_FIELDS = 12;
	localparam int FILL_AT = 700;
	localparam int QUIET_AT = 1400;
	localparam int RANDOM_END = 1600;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [ACT_W-1:0]   act;
		logic [BYTE_W-1:0]  key;
		logic [CNT16_W-1:0] req;
		bit                 fixed;
		res_t               want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;    // key_code[7:0], request_count[23:8]
	logic [1:0]  s_axis_tuser = '0;    // action[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;         // push_dropped .. fill_level, see the block's port list

	logic [BYTE_W-1:0]  kb_ring [RING_SLOTS];
	int                 kb_wr = 0;
	int                 kb_rd = 0;
	int                 kb_held = 0;
	logic [CNT16_W-1:0] line_left = '0;
	logic [CNT16_W-1:0] line_taken = '0;

	res_t pending_results [$];
	int   n_items = 0;
	int   mismatches = 0;
	int   cycles = 0;
	int   rx_hold = 0;
	bit   quiet = 1'b0;

	int    fld_lo [N_FIELDS] = '{0, 1, 2, 3, 11, 12, 13, 29, 37, 38, 54, 63};
	int    fld_w  [N_FIELDS] = '{1, 1, 1, 8, 1, 1, 16, 8, 1, 16, 9, 1};
	string fld_name [N_FIELDS] = '{"push_dropped", "popped_valid", "echo_valid", "echo_char",
		"echo_newline", "store_valid", "store_offset", "store_byte", "done_res", "done_count",
		"fill_level", "padding"};

	row_t plan [N_DIRECTED] = '{
		'{ACT_POP,  8'h00,    16'h0000, 1'b1, '0},
		'{ACT_NONE, 8'hFF,    16'hFFFF, 1'b1, '0},
		'{ACT_ARM,  8'h00,    16'h0000, 1'b1, '0},
		'{ACT_PUSH, 8'h41,    16'h0000, 1'b1, res_t'{fill_level: 9'd1, default: '0}},
		'{ACT_POP,  8'h00,    16'h0000, 1'b1, res_t'{popped_valid: 1'b1, default: '0}},
		'{ACT_ARM,  8'h00,    16'hFFFF, 1'b1, '0},
		'{ACT_PUSH, 8'h00,    16'h0000, 1'b1, res_t'{fill_level: 9'd1, default: '0}},
		'{ACT_PUSH, 8'hFF,    16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_SPACE, 16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_TILDE, 16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_BS,    16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_BS,    16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_BS,    16'h0000, 1'b0, '0},
		'{ACT_PUSH, CH_NL,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0},
		'{ACT_ARM,  8'h00,    16'h0001, 1'b1, '0},
		'{ACT_PUSH, 8'h7A,    16'h0000, 1'b1, res_t'{fill_level: 9'd1, default: '0}},
		'{ACT_POP,  8'h00,    16'h0000, 1'b0, '0}
	};

	tty_line_discipline #(.RING_DEPTH(RING_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic res_t predict_line_result(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] key,
			logic [CNT16_W-1:0] req);
		res_t r;
		logic [BYTE_W-1:0] ch;
		r = '0;
		case (act)
			ACT_PUSH: begin
				if (kb_held < RING_SLOTS) begin
					kb_ring[kb_wr] = key;
					kb_wr = (kb_wr + 1) % RING_SLOTS;
					kb_held++;
				end else begin
					r.push_dropped = 1'b1;
				end
			end
			ACT_ARM: begin
				line_left = req;
				line_taken = '0;
			end
			ACT_POP: begin
				if (kb_held != 0) begin
					ch = kb_ring[kb_rd];
					kb_rd = (kb_rd + 1) % RING_SLOTS;
					kb_held--;
					r.popped_valid = 1'b1;
					if (line_left != 0) begin
						if (ch >= CH_SPACE && ch <= CH_TILDE) begin
							r.echo_valid = 1'b1;
							r.echo_char = ch;
							r.store_valid = 1'b1;
							r.store_offset = line_taken;
							r.store_byte = ch;
							if (line_taken != CNT16_MAX)
								line_taken++;
							line_left--;
						end else if (ch == CH_BS && line_taken != 0) begin
							r.echo_valid = 1'b1;
							r.echo_char = ch;
							line_taken--;
							if (line_left != CNT16_MAX)
								line_left++;
						end
						if (ch == CH_NL || line_left == 0) begin
							r.echo_newline = 1'b1;
							r.done_res = 1'b1;
							r.done_count = line_taken;
							line_left = '0;
						end
					end
				end
			end
			default: ;
		endcase
		r.fill_level = FILL_W'(kb_held);
		return r;
	endfunction

	function automatic logic [63:0] result_bus(res_t r);
		return {1'b0, r.fill_level, r.done_count, r.done_res, r.store_byte, r.store_offset,
			r.store_valid, r.echo_newline, r.echo_char, r.echo_valid, r.popped_valid,
			r.push_dropped};
	endfunction

	function automatic logic [BYTE_W-1:0] random_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return BYTE_W'($urandom_range(CH_SPACE, CH_TILDE));
		else if (sel < 75)
			return CH_BS;
		else if (sel < 85)
			return CH_NL;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] key,
			input logic [CNT16_W-1:0] req, input bit fixed, input res_t want);
		res_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {req, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = predict_line_result(act, key, req);
		pending_results.push_back(fixed ? want : r);
		n_items++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11))
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// arm a request, then interleave pushes of one typed line with pops until the ring is empty
	task automatic line_session();
		logic [BYTE_W-1:0] line [$];
		int sel;
		int n;
		int pushed;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			send_item(ACT_ARM, BYTE_W'($urandom_range(0, 255)),
				CNT16_W'($urandom_range(1, 24)), 1'b0, '0);
		else if (sel == 7)
			send_item(ACT_ARM, BYTE_W'($urandom_range(0, 255)), '0, 1'b0, '0);
		else
			send_item(ACT_ARM, BYTE_W'($urandom_range(0, 255)),
				CNT16_W'($urandom_range(0, 65535)), 1'b0, '0);
		n = $urandom_range(1, 20);
		for (int j = 0; j < n; j++)
			line.push_back(random_key());
		pushed = 0;
		while (pushed < n || kb_held != 0) begin
			if (pushed < n && (kb_held == 0 || $urandom_range(0, 1) == 0)) begin
				send_item(ACT_PUSH, line[pushed], CNT16_W'($urandom_range(0, 65535)), 1'b0, '0);
				pushed++;
			end else begin
				send_item(ACT_POP, BYTE_W'($urandom_range(0, 255)),
					CNT16_W'($urandom_range(0, 65535)), 1'b0, '0);
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_item(ACT_POP, '0, '0, 1'b0, '0);
	endtask

	// fill the ring past full, then read it all back under one long request
	task automatic fill_and_drain();
		while (kb_held < RING_SLOTS)
			send_item(ACT_PUSH, random_key(), '0, 1'b0, '0);
		repeat (3)
			send_item(ACT_PUSH, BYTE_W'($urandom_range(0, 255)), '0, 1'b0, '0);
		send_item(ACT_ARM, '0, CNT16_W'($urandom_range(200, 65535)), 1'b0, '0);
		while (kb_held != 0)
			send_item(ACT_POP, '0, '0, 1'b0, '0);
		repeat (2)
			send_item(ACT_POP, '0, '0, 1'b0, '0);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			rx_hold <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [63:0] want_bus;
		logic [63:0] want_f;
		logic [63:0] got_f;
		logic [63:0] mask;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want_bus = result_bus(pending_results.pop_front());
				for (int i = 0; i < N_FIELDS; i++) begin
					mask = (64'd1 << fld_w[i]) - 64'd1;
					want_f = (want_bus >> fld_lo[i]) & mask;
					got_f = (m_axis_tdata >> fld_lo[i]) & mask;
					if (got_f !== want_f) begin
						$display("%0t: %s expected %0h actual %0h", $time, fld_name[i], want_f,
							got_f);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		bit filled;
		filled = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < N_DIRECTED; k++)
			send_item(plan[k].act, plan[k].key, plan[k].req, plan[k].fixed, plan[k].want);
		drain_results();
		while (n_items < RANDOM_END) begin
			if (!filled && n_items >= FILL_AT) begin
				fill_and_drain();
				filled = 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				send_item(ACT_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
					CNT16_W'($urandom_range(0, 65535)), 1'b0, '0);
			end else begin
				line_session();
			end
			if (n_items >= QUIET_AT)
				quiet = 1'b1;
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
